// ===== rtl/rprank_pkg.sv =====
// shared constants, codes and state type for the reader progress percentile rank block
`default_nettype none
package rprank_pkg;

   localparam int USERS     = 1024;
   localparam int PAGES     = 1024;
   localparam int FRAC_BITS = 16;

   localparam int USER_IN_W = 10;
   localparam int PAGE_IN_W = 10;
   localparam int RATIO_W   = FRAC_BITS + 1;

   localparam int USER_AW  = $clog2(USERS);
   localparam int PAGE_AW  = $clog2(PAGES);
   localparam int COUNT_W  = $clog2(USERS + 1);
   localparam int CLR_N    = (USERS > PAGES) ? USERS : PAGES;
   localparam int CLR_W    = $clog2(CLR_N);
   localparam int DIV_CW   = $clog2(FRAC_BITS);

   localparam int REQ_DATA_W = ((USER_IN_W + PAGE_IN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RATIO_W + 7) / 8) * 8;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_CHEER = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPD_OLD,
      ST_UPD_DEC,
      ST_UPD_NEW,
      ST_UPD_INC,
      ST_CHECK,
      ST_SUM,
      ST_SUM_LAST,
      ST_DIV_INIT,
      ST_DIV,
      ST_RESULT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/rprank_ram.sv =====
// generic single write port, single read port ram with registered read data
`default_nettype none
module rprank_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/reader_progress_percentile_rank.sv =====
// top level: per-user page table, page histogram and percentile rank query engine
//
// Items are taken one at a time. After reset the block sweeps its flag and
// histogram memories before it takes the first word. A read update does one
// lookup of the user memories, then a read-modify-write of the old histogram
// bucket (for a known user only) and of the new one. In a cheer query the
// histogram memory's single read port gives one bucket per cycle below the
// user's page, followed by a restoring division; unknown users and lone users
// skip both. A result waits in an output register, and the next word is taken
// meanwhile.
`default_nettype none
module reader_progress_percentile_rank (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rprank_pkg::REQ_DATA_W-1:0] req_tdata,  // user, page, zero fill
   input  wire logic                              req_tuser,  // req_type
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [rprank_pkg::RSP_DATA_W-1:0] rsp_tdata   // cheer_ratio, zero fill
);

   localparam int USER_AW = rprank_pkg::USER_AW;
   localparam int PAGE_AW = rprank_pkg::PAGE_AW;
   localparam int COUNT_W = rprank_pkg::COUNT_W;
   localparam int RATIO_W = rprank_pkg::RATIO_W;
   localparam int FRAC    = rprank_pkg::FRAC_BITS;

   rprank_pkg::state_type state_ff, state_in;

   logic [rprank_pkg::CLR_W-1:0] clr_idx_ff, clr_idx_in;
   logic                         type_ff, type_in;
   logic [USER_AW-1:0]           user_ff, user_in;
   logic                         user_ok_ff, user_ok_in;
   logic [PAGE_AW-1:0]           page_ff, page_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic [PAGE_AW-1:0]           idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [COUNT_W-1:0]           sum_ff, sum_in;
   logic [COUNT_W-1:0]           rem_ff, rem_in;
   logic [FRAC-1:0]              q_ff, q_in;
   logic [rprank_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic [RATIO_W-1:0]           ratio_ff, ratio_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0]           rsp_data_ff, rsp_data_in;

   logic [rprank_pkg::USER_IN_W-1:0] req_user;
   logic [rprank_pkg::PAGE_IN_W-1:0] req_page;

   // user memories
   logic               usr_wr_en, usr_rd_en;
   logic [USER_AW-1:0] usr_wr_addr;
   logic [PAGE_AW-1:0] upage_wr_data, upage_rd;
   logic               flag_wr_data, flag_rd;

   // histogram memory
   logic               hist_wr_en, hist_rd_en;
   logic [PAGE_AW-1:0] hist_wr_addr, hist_rd_addr;
   logic [COUNT_W-1:0] hist_wr_data, hist_rd;

   logic [COUNT_W-1:0] others;
   logic [COUNT_W-1:0] below;
   logic [COUNT_W:0]   rem_sh;
   logic [COUNT_W:0]   rem_diff;
   logic               req_fire;

   assign req_user = req_tdata[rprank_pkg::USER_IN_W-1:0];
   assign req_page = req_tdata[rprank_pkg::USER_IN_W +: rprank_pkg::PAGE_IN_W];
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == rprank_pkg::ST_IDLE);

   assign others   = count_ff - COUNT_W'(1);
   assign below    = (sum_ff > others) ? others : sum_ff;
   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_diff = rem_sh - {1'b0, others};

   rprank_ram #(.WIDTH(PAGE_AW), .DEPTH(rprank_pkg::USERS)) u_page_ram (
      .clock   (clock),
      .wr_en   (usr_wr_en && !(state_ff == rprank_pkg::ST_CLEAR)),
      .wr_addr (usr_wr_addr),
      .wr_data (upage_wr_data),
      .rd_en   (usr_rd_en),
      .rd_addr (user_ff),
      .rd_data (upage_rd)
   );

   rprank_ram #(.WIDTH(1), .DEPTH(rprank_pkg::USERS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (usr_wr_en),
      .wr_addr (usr_wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (usr_rd_en),
      .rd_addr (user_ff),
      .rd_data (flag_rd)
   );

   rprank_ram #(.WIDTH(COUNT_W), .DEPTH(rprank_pkg::PAGES)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rprank_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      user_ff     <= user_in;
      user_ok_ff  <= user_ok_in;
      page_ff     <= page_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      ratio_ff    <= ratio_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      type_in       = type_ff;
      user_in       = user_ff;
      user_ok_in    = user_ok_ff;
      page_in       = page_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      ratio_in      = ratio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      usr_wr_en     = 1'b0;
      usr_rd_en     = 1'b0;
      usr_wr_addr   = user_ff;
      upage_wr_data = page_ff;
      flag_wr_data  = 1'b1;
      hist_wr_en    = 1'b0;
      hist_rd_en    = 1'b0;
      hist_wr_addr  = page_ff;
      hist_rd_addr  = page_ff;
      hist_wr_data  = hist_rd + COUNT_W'(1);

      case (state_ff)
         rprank_pkg::ST_CLEAR: begin
            usr_wr_en    = 32'(clr_idx_ff) < rprank_pkg::USERS;
            usr_wr_addr  = USER_AW'(clr_idx_ff);
            flag_wr_data = 1'b0;
            hist_wr_en   = 32'(clr_idx_ff) < rprank_pkg::PAGES;
            hist_wr_addr = PAGE_AW'(clr_idx_ff);
            hist_wr_data = '0;
            if (32'(clr_idx_ff) == rprank_pkg::CLR_N - 1) begin
               state_in = rprank_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + rprank_pkg::CLR_W'(1);
            end
         end
         rprank_pkg::ST_IDLE: begin
            if (req_fire) begin
               type_in    = req_tuser;
               user_in    = USER_AW'(req_user);
               user_ok_in = 32'(req_user) < rprank_pkg::USERS;
               page_in    = (32'(req_page) >= rprank_pkg::PAGES) ?
                            PAGE_AW'(rprank_pkg::PAGES - 1) : PAGE_AW'(req_page);
               state_in   = rprank_pkg::ST_LOOKUP;
            end
         end
         rprank_pkg::ST_LOOKUP: begin
            usr_rd_en = 1'b1;
            state_in  = (type_ff == rprank_pkg::REQ_CHEER) ?
                        rprank_pkg::ST_CHECK : rprank_pkg::ST_UPD_OLD;
         end
         rprank_pkg::ST_UPD_OLD: begin
            if (!user_ok_ff) begin
               state_in = rprank_pkg::ST_IDLE;
            end else if (flag_rd) begin
               hist_rd_en   = 1'b1;
               hist_rd_addr = upage_rd;
               state_in     = rprank_pkg::ST_UPD_DEC;
            end else begin
               count_in = count_ff + COUNT_W'(1);
               state_in = rprank_pkg::ST_UPD_NEW;
            end
         end
         rprank_pkg::ST_UPD_DEC: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = upage_rd;
            hist_wr_data = (hist_rd != '0) ? hist_rd - COUNT_W'(1) : hist_rd;
            state_in     = rprank_pkg::ST_UPD_NEW;
         end
         rprank_pkg::ST_UPD_NEW: begin
            hist_rd_en = 1'b1;
            usr_wr_en  = 1'b1;
            state_in   = rprank_pkg::ST_UPD_INC;
         end
         rprank_pkg::ST_UPD_INC: begin
            hist_wr_en = 1'b1;
            state_in   = rprank_pkg::ST_IDLE;
         end
         rprank_pkg::ST_CHECK: begin
            page_in = upage_rd;
            sum_in  = '0;
            idx_in  = '0;
            pend_in = 1'b0;
            if (!user_ok_ff || !flag_rd) begin
               ratio_in = '0;
               state_in = rprank_pkg::ST_RESULT;
            end else if (count_ff <= COUNT_W'(1)) begin
               ratio_in = RATIO_W'(1) << FRAC;
               state_in = rprank_pkg::ST_RESULT;
            end else if (upage_rd == '0) begin
               state_in = rprank_pkg::ST_DIV_INIT;
            end else begin
               state_in = rprank_pkg::ST_SUM;
            end
         end
         rprank_pkg::ST_SUM: begin
            hist_rd_en   = 1'b1;
            hist_rd_addr = idx_ff;
            pend_in      = 1'b1;
            if (pend_ff) begin
               sum_in = sum_ff + hist_rd;
            end
            if (idx_ff == page_ff - PAGE_AW'(1)) begin
               state_in = rprank_pkg::ST_SUM_LAST;
            end else begin
               idx_in = idx_ff + PAGE_AW'(1);
            end
         end
         rprank_pkg::ST_SUM_LAST: begin
            sum_in   = sum_ff + hist_rd;
            state_in = rprank_pkg::ST_DIV_INIT;
         end
         rprank_pkg::ST_DIV_INIT: begin
            rem_in = below;
            q_in   = '0;
            cnt_in = '0;
            if (below == others) begin
               ratio_in = RATIO_W'(1) << FRAC;
               state_in = rprank_pkg::ST_RESULT;
            end else begin
               state_in = rprank_pkg::ST_DIV;
            end
         end
         rprank_pkg::ST_DIV: begin
            if (rem_sh >= {1'b0, others}) begin
               rem_in = COUNT_W'(rem_diff);
               q_in   = {q_ff[FRAC-2:0], 1'b1};
            end else begin
               rem_in = COUNT_W'(rem_sh);
               q_in   = {q_ff[FRAC-2:0], 1'b0};
            end
            if (32'(cnt_ff) == FRAC - 1) begin
               ratio_in = {1'b0, q_in};
               state_in = rprank_pkg::ST_RESULT;
            end else begin
               cnt_in = cnt_ff + rprank_pkg::DIV_CW'(1);
            end
         end
         rprank_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ratio_ff;
               state_in     = rprank_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rprank_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rprank_pkg::RSP_DATA_W'(rsp_data_ff);

endmodule
`default_nettype wire

// ===== tb/reader_progress_percentile_rank_test.sv =====
// testbench for reader_progress_percentile_rank: directed and random read and cheer traffic
`timescale 1ns / 1ps
module reader_progress_percentile_rank_test;

   localparam int   USERS      = rprank_pkg::USERS;
   localparam int   PAGES      = rprank_pkg::PAGES;
   localparam int   FRAC_BITS  = rprank_pkg::FRAC_BITS;
   localparam int   USER_IN_W  = rprank_pkg::USER_IN_W;
   localparam int   PAGE_IN_W  = rprank_pkg::PAGE_IN_W;
   localparam int   RATIO_W    = rprank_pkg::RATIO_W;
   localparam int   CLR_N      = rprank_pkg::CLR_N;
   localparam int   REQ_DATA_W = rprank_pkg::REQ_DATA_W;
   localparam int   RSP_DATA_W = rprank_pkg::RSP_DATA_W;
   localparam logic REQ_READ   = rprank_pkg::REQ_READ;
   localparam logic REQ_CHEER  = rprank_pkg::REQ_CHEER;

   localparam int RANDOM_ITEMS = 520;
   localparam int POOL_N       = 48;
   localparam int DRAIN_CYCLES = PAGES + 64;
   localparam int STALL_LIMIT  = 8 * (CLR_N + PAGES + 100);

   class percentile_tracker;
      bit                   known_flag[USERS];
      logic [PAGE_IN_W-1:0] last_page[USERS];
      int unsigned          bucket[PAGES];
      int unsigned          known_n;
      logic [RATIO_W-1:0]   ratio_due[$];
      int                   errors;
      int                   n_reads;
      int                   n_cheers;
      int                   n_unknown;
      int                   n_lone;
      int                   n_checked;

      function new();
         foreach (known_flag[i]) known_flag[i] = 1'b0;
         foreach (bucket[i]) bucket[i] = 0;
         known_n = 0;
         errors = 0;
         n_reads = 0;
         n_cheers = 0;
         n_unknown = 0;
         n_lone = 0;
         n_checked = 0;
      endfunction

      function bit is_known(logic [USER_IN_W-1:0] user);
         return (int'(user) < USERS) && known_flag[user];
      endfunction

      function logic [PAGE_IN_W-1:0] page_of(logic [USER_IN_W-1:0] user);
         return last_page[user];
      endfunction

      function int pending();
         return ratio_due.size();
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      function logic [RATIO_W-1:0] rank_of(logic [USER_IN_W-1:0] user);
         longint unsigned below;
         longint unsigned others;
         int              p;
         below = 0;
         if (!is_known(user)) begin
            n_unknown++;
            return '0;
         end
         if (known_n <= 1) begin
            n_lone++;
            return RATIO_W'(1) << FRAC_BITS;
         end
         p = int'(last_page[user]);
         if (p >= PAGES) p = PAGES - 1;
         for (int i = 0; i < p; i++) below += bucket[i];
         others = known_n - 1;
         if (below > others) below = others;
         return RATIO_W'((below << FRAC_BITS) / others);
      endfunction

      function void take_request(logic kind, logic [USER_IN_W-1:0] user,
                                 logic [PAGE_IN_W-1:0] page);
         int p;
         if (kind == REQ_CHEER) begin
            n_cheers++;
            ratio_due.push_back(rank_of(user));
            return;
         end
         n_reads++;
         if (int'(user) >= USERS) return;
         p = (int'(page) >= PAGES) ? PAGES - 1 : int'(page);
         if (known_flag[user]) begin
            if (int'(last_page[user]) < PAGES && bucket[last_page[user]] > 0)
               bucket[last_page[user]]--;
         end else begin
            known_flag[user] = 1'b1;
            known_n++;
         end
         last_page[user] = PAGE_IN_W'(p);
         bucket[p]++;
      endfunction

      task match_ratio(logic [RATIO_W-1:0] got);
         logic [RATIO_W-1:0] want;
         n_checked++;
         if (ratio_due.size() == 0) begin
            report_mismatch($sformatf("ratio %0d arrived with no cheer outstanding", got));
         end else begin
            want = ratio_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("cheer_ratio %0d, predicted %0d", got, want));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // user, page, zero fill
   logic                  req_tuser = 1'b0;  // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // cheer_ratio, zero fill

   percentile_tracker     sb = new();
   bit                    no_idle = 1'b0;
   int                    quiet_cycles = 0;

   reader_progress_percentile_rank i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   task automatic send_word(input logic kind, input logic [USER_IN_W-1:0] user,
                            input logic [PAGE_IN_W-1:0] page);
      int                    gap;
      logic [REQ_DATA_W-1:0] word;
      gap = pick_gap();
      word = '0;
      word[USER_IN_W-1:0] = user;
      word[USER_IN_W +: PAGE_IN_W] = page;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= REQ_DATA_W'($urandom);
         req_tuser <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      sb.take_request(kind, user, page);
   endtask

   task automatic wait_all_answered();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // result side back-pressure
   initial begin : rsp_side
      int on_n;
      int off_n;
      forever begin
         on_n = $urandom_range(1, 20);
         off_n = pick_gap();
         rsp_tready <= 1'b1;
         repeat (on_n) @(posedge clock);
         if (off_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (off_n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_ratio(rsp_tdata[RATIO_W-1:0]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [USER_IN_W-1:0] pool[POOL_N];
      logic [USER_IN_W-1:0] user;
      logic [PAGE_IN_W-1:0] page;
      logic                 kind;
      int                   r;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // nobody known yet
      send_word(REQ_CHEER, 10'd5, 10'd0);
      send_word(REQ_READ, 10'd5, 10'd100);
      // lone user, page field ignored
      send_word(REQ_CHEER, 10'd5, 10'h3ff);
      send_word(REQ_READ, 10'h3ff, 10'h3ff);
      send_word(REQ_READ, 10'd0, 10'd0);
      send_word(REQ_CHEER, 10'h3ff, 10'd0);
      send_word(REQ_CHEER, 10'd0, 10'd7);
      send_word(REQ_CHEER, 10'd5, 10'd0);
      // same page again leaves state alone
      send_word(REQ_READ, 10'd5, 10'd100);
      send_word(REQ_CHEER, 10'd5, 10'd0);
      // equal page is not lower
      send_word(REQ_READ, 10'd5, 10'd0);
      send_word(REQ_CHEER, 10'd5, 10'd0);
      send_word(REQ_CHEER, 10'h3ff, 10'd0);
      send_word(REQ_READ, 10'h2aa, 10'h155);
      send_word(REQ_READ, 10'h155, 10'h2aa);
      send_word(REQ_READ, 10'd100, 10'd500);
      send_word(REQ_CHEER, 10'h155, 10'h155);
      send_word(REQ_CHEER, 10'h2aa, 10'h2aa);
      send_word(REQ_CHEER, 10'd77, 10'd0);
      req_tvalid <= 1'b0;
      wait_all_answered();

      foreach (pool[i]) pool[i] = USER_IN_W'($urandom_range(0, USERS - 1));
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            wait_all_answered();
         end
         no_idle = (k >= 300 && k < 360);
         r = $urandom_range(0, 99);
         user = (r < 85) ? pool[$urandom_range(0, POOL_N - 1)]
                         : USER_IN_W'($urandom_range(0, USERS - 1));
         kind = ($urandom_range(0, 99) < 45) ? REQ_CHEER : REQ_READ;
         r = $urandom_range(0, 99);
         if (r < 8 && sb.is_known(user)) page = sb.page_of(user);
         else if (r < 70) page = PAGE_IN_W'($urandom_range(0, 127));
         else if (r < 75) page = (r < 73) ? '1 : '0;
         else page = PAGE_IN_W'($urandom_range(0, 1023));
         send_word(kind, user, page);
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d reads, %0d cheers (%0d for unknown users, %0d for a lone user)",
               sb.n_reads, sb.n_cheers, sb.n_unknown, sb.n_lone);
      $display("run: %0d known users at the end, %0d ratios checked, %0d mismatches",
               sb.known_n, sb.n_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rprank_pkg.sv
rtl/rprank_ram.sv
rtl/reader_progress_percentile_rank.sv
tb/reader_progress_percentile_rank_test.sv
